// ----- hw/rtl/imbt_pkg.sv -----
// Shared constants, codes and control types for the IP-to-MAC binding table.
`timescale 1ns / 1ps
package imbt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int MODE_W = 3;
  localparam int ORD_W = 5;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SEEN_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (SEEN_W > ORD_W) ? SEEN_W : ORD_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT     = 3'd0,
    MODE_LOOKUP_IP  = 3'd1,
    MODE_LOOKUP_MAC = 3'd2,
    MODE_READ_ORD   = 3'd3,
    MODE_DELETE_ORD = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/imbt_ctrl.sv -----
// Controller state machine: accept, slot scan and result hand-off.
`timescale 1ns / 1ps
module imbt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  imbt_pkg::sts_t sts,
  output imbt_pkg::cmd_t cmd
);

  imbt_pkg::state_t state;
  imbt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      imbt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = imbt_pkg::ST_SCAN;
        end
      end
      imbt_pkg::ST_SCAN: begin
        if (sts.hit || sts.scan_end) begin
          state_next = imbt_pkg::ST_DONE;
        end
      end
      imbt_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_next = imbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = imbt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      imbt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      imbt_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
      end
      imbt_pkg::ST_DONE: begin
        cmd.publish = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- hw/rtl/imbt_dp.sv -----
// Datapath: slot stores, valid bits, scan index, match logic and output register.
`timescale 1ns / 1ps
module imbt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [imbt_pkg::MODE_W-1:0]   mode,
  input  logic [imbt_pkg::IP_W-1:0]     ip_in,
  input  logic [imbt_pkg::MAC_W-1:0]    mac_in,
  input  logic [imbt_pkg::ORD_W-1:0]    ordinal,
  input  imbt_pkg::cmd_t                cmd,
  output imbt_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic [imbt_pkg::IP_W-1:0]     ip_out,
  output logic [imbt_pkg::MAC_W-1:0]    mac_out
);

  logic [imbt_pkg::IP_W-1:0]  slot_ip  [imbt_pkg::TABLE_DEPTH];
  logic [imbt_pkg::MAC_W-1:0] slot_mac [imbt_pkg::TABLE_DEPTH];
  logic [imbt_pkg::TABLE_DEPTH-1:0] slot_valid;

  logic [imbt_pkg::MODE_W-1:0] op_mode;
  logic [imbt_pkg::IP_W-1:0]   op_ip;
  logic [imbt_pkg::MAC_W-1:0]  op_mac;
  logic [imbt_pkg::ORD_W-1:0]  op_ord;
  logic [imbt_pkg::IDX_W-1:0]  idx;
  logic [imbt_pkg::IDX_W-1:0]  idx_next;
  logic [imbt_pkg::SEEN_W-1:0] seen;
  logic                        res_ok;
  logic [imbt_pkg::IP_W-1:0]   res_ip;
  logic [imbt_pkg::MAC_W-1:0]  res_mac;

  logic                        cur_valid;
  logic [imbt_pkg::IP_W-1:0]   cur_ip;
  logic [imbt_pkg::MAC_W-1:0]  cur_mac;
  logic                        ord_match;
  logic                        hit;
  logic                        bad_mode;
  logic                        last;
  logic                        do_insert;
  logic                        do_delete;

  assign idx_next  = cmd.load ? '0 :
                     (cmd.step ? idx + imbt_pkg::IDX_W'(1) : idx);
  assign cur_valid = slot_valid[idx];
  assign last      = (idx == imbt_pkg::IDX_W'(imbt_pkg::TABLE_DEPTH - 1));
  assign ord_match = cur_valid &&
                     (imbt_pkg::CMP_W'(seen) + imbt_pkg::CMP_W'(1) ==
                      imbt_pkg::CMP_W'(op_ord));

  always_comb begin
    hit = 1'b0;
    bad_mode = 1'b0;
    case (imbt_pkg::mode_t'(op_mode))
      imbt_pkg::MODE_INSERT:     hit = !cur_valid;
      imbt_pkg::MODE_LOOKUP_IP:  hit = cur_valid && (cur_ip == op_ip);
      imbt_pkg::MODE_LOOKUP_MAC: hit = cur_valid && (cur_mac == op_mac);
      imbt_pkg::MODE_READ_ORD:   hit = ord_match;
      imbt_pkg::MODE_DELETE_ORD: hit = ord_match;
      default:                   bad_mode = 1'b1;
    endcase
  end

  assign do_insert = cmd.step && hit &&
                     (op_mode == imbt_pkg::MODE_W'(imbt_pkg::MODE_INSERT));
  assign do_delete = cmd.step && hit &&
                     (op_mode == imbt_pkg::MODE_W'(imbt_pkg::MODE_DELETE_ORD));

  assign sts.hit      = hit;
  assign sts.scan_end = last || bad_mode;
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (do_insert) begin
      slot_ip[idx]  <= op_ip;
      slot_mac[idx] <= op_mac;
    end
    cur_ip  <= slot_ip[idx_next];
    cur_mac <= slot_mac[idx_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (do_insert) begin
        slot_valid[idx] <= 1'b1;
      end else if (do_delete) begin
        slot_valid[idx] <= 1'b0;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= mode;
      op_ip   <= ip_in;
      op_mac  <= mac_in;
      op_ord  <= ordinal;
      idx     <= '0;
      seen    <= '0;
      res_ok  <= 1'b0;
      res_ip  <= '0;
      res_mac <= '0;
    end else if (cmd.step) begin
      idx <= idx + imbt_pkg::IDX_W'(1);
      if (cur_valid) begin
        seen <= seen + imbt_pkg::SEEN_W'(1);
      end
      if (hit) begin
        res_ok <= 1'b1;
        if (op_mode == imbt_pkg::MODE_W'(imbt_pkg::MODE_READ_ORD)) begin
          res_ip  <= cur_ip;
          res_mac <= cur_mac;
        end else if (op_mode == imbt_pkg::MODE_W'(imbt_pkg::MODE_LOOKUP_IP)) begin
          res_mac <= cur_mac;
        end
      end
    end
    if (cmd.publish) begin
      ok      <= res_ok;
      ip_out  <= res_ip;
      mac_out <= res_mac;
    end
  end

endmodule

// ----- hw/rtl/ip_mac_binding_table.sv -----
// Top level of the IP-to-MAC binding table.
`timescale 1ns / 1ps
// Each item runs one operation against a 16-slot table, scanning one slot per
// cycle from slot 0 through a single registered read port of the slot store.
// An item is accepted, then scanned (the scan stops at the first matching slot
// or at the last slot; unused modes stop after the first slot) and then its
// result is loaded into the output register. One item is in work at a time;
// the result waits in the output register while the next item is accepted,
// and a result still stalled there holds the next item before its output load.
module ip_mac_binding_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [imbt_pkg::MODE_W-1:0] mode,
  input  logic [imbt_pkg::IP_W-1:0]   ip_in,
  input  logic [imbt_pkg::MAC_W-1:0]  mac_in,
  input  logic [imbt_pkg::ORD_W-1:0]  ordinal,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        ok,
  output logic [imbt_pkg::IP_W-1:0]   ip_out,
  output logic [imbt_pkg::MAC_W-1:0]  mac_out
);

  imbt_pkg::cmd_t cmd;
  imbt_pkg::sts_t sts;

  imbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  imbt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .ip_in     (ip_in),
    .mac_in    (mac_in),
    .ordinal   (ordinal),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .ip_out    (ip_out),
    .mac_out   (mac_out)
  );

endmodule
